>>> hdl/hbfd_pkg.sv
// Shared types and constants for the HVAC bus frame decoder.
// No dependencies; used by every module in hdl/.
package hbfd_pkg;

  localparam int unsigned FRAME_BODY_BYTES = 13;
  localparam int unsigned COUNT_W          = 4;

  localparam logic [7:0] START_BYTE   = 8'h32;
  localparam logic [7:0] END_BYTE     = 8'h34;
  localparam logic [7:0] CMD_STATUS   = 8'h52;
  localparam logic [7:0] CMD_MODE     = 8'h53;
  localparam logic [7:0] UNIT_ADDR_RST = 8'h84;

  localparam logic [4:0] TEMP_MASK   = 5'h1F;
  localparam logic [5:0] TEMP_OFFSET = 6'd9;

  localparam logic [3:0] FAN_NIB_LOW  = 4'hA;
  localparam logic [3:0] FAN_NIB_MED  = 4'hC;
  localparam logic [3:0] FAN_NIB_HIGH = 4'hD;

  localparam logic [1:0] FAN_AUTO = 2'd0;
  localparam logic [1:0] FAN_LOW  = 2'd1;
  localparam logic [1:0] FAN_MED  = 2'd2;
  localparam logic [1:0] FAN_HIGH = 2'd3;

  localparam logic [7:0] MODE_MAX = 8'd4;

  // Fixed body positions
  localparam logic [COUNT_W-1:0] POS_DEST  = 4'd1;
  localparam logic [COUNT_W-1:0] POS_CMD   = 4'd2;
  localparam logic [COUNT_W-1:0] POS_DATA0 = 4'd3;
  localparam logic [COUNT_W-1:0] POS_DATA3 = 4'd6;
  localparam logic [COUNT_W-1:0] POS_DATA4 = 4'd7;
  localparam logic [COUNT_W-1:0] POS_DATA7 = 4'd10;
  localparam logic [COUNT_W-1:0] POS_CSUM  = 4'd11;
  localparam logic [COUNT_W-1:0] POS_END   = 4'd12;

  // A checked frame, handed from the collector to the state tracker
  typedef struct packed {
    logic       ok;
    logic [7:0] dest;
    logic [7:0] cmd;
    logic [7:0] data0;
    logic [7:0] data3;
    logic [7:0] data4;
    logic [7:0] data7;
  } frame_t;

  typedef struct packed {
    logic [5:0] temperature;
    logic       power_on;
    logic [1:0] fan_level;
    logic [2:0] op_mode;
    logic [7:0] frame_destination;
    logic       state_changed;
  } result_t;

endpackage

>>> hdl/hvac_bus_frame_decoder_unit.sv
// HVAC bus frame decoder, top level: input byte register, collector, tracker,
// result register. Depends on hbfd_pkg, hbfd_collect and hbfd_tracker.
//
// Usage:
//   Input channel (in_valid / in_stall, rx_byte) takes one bus byte per
//   transfer. Output channel (out_valid / out_stall) gives one result per
//   valid frame: tracked temperature, power_on, fan_level, op_mode, the
//   frame's destination and state_changed. Bytes outside a frame and
//   frames that fail the end-byte or XOR check give nothing.
//   Config channel (cfg_valid / cfg_ready, unit_address) sets the address
//   that status and mode frames must carry; write it only while idle.
// Timing:
//   One byte per cycle sustained while no result is stalled. A result is
//   in the output register once the frame's end byte has waited in the
//   input register and a single decode pass has filled the result register.
// Reset (rst, synchronous): hunting for the start byte, tracked state all
//   zero, unit address 0x84, both registers empty.
// Stall: a stalled result holds; one more byte still lands in the input
//   register, then in_stall rises until the result is taken.
module hvac_bus_frame_decoder_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [5:0] temperature,
  output logic       power_on,
  output logic [1:0] fan_level,
  output logic [2:0] op_mode,
  output logic [7:0] frame_destination,
  output logic       state_changed,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] unit_address
);

  logic       byte_valid;
  logic [7:0] byte_data;
  logic [7:0] addr;
  logic       advance;
  logic       step;

  hbfd_pkg::frame_t  frame;
  hbfd_pkg::result_t result;

  assign advance   = !out_valid || !out_stall;
  assign step      = byte_valid && advance;
  assign in_stall  = byte_valid && !advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= hbfd_pkg::UNIT_ADDR_RST;
    end else if (cfg_valid && cfg_ready) begin
      addr <= unit_address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!in_stall) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_data <= rx_byte;
    end
  end

  hbfd_collect u_collect (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (byte_data),
    .frame   (frame)
  );

  hbfd_tracker u_tracker (
    .clk          (clk),
    .rst          (rst),
    .frame        (frame),
    .unit_address (addr),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= frame.ok;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && frame.ok) begin
      temperature       <= result.temperature;
      power_on          <= result.power_on;
      fan_level         <= result.fan_level;
      op_mode           <= result.op_mode;
      frame_destination <= result.frame_destination;
      state_changed     <= result.state_changed;
    end
  end

endmodule

>>> hdl/hbfd_collect.sv
// Frame collector: start-byte hunt, body capture, XOR checksum and end-byte check.
// Depends on hbfd_pkg.
module hbfd_collect (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  output hbfd_pkg::frame_t  frame
);

  localparam int unsigned STORE_DEPTH = hbfd_pkg::FRAME_BODY_BYTES - 1;

  logic                              collecting;
  logic [hbfd_pkg::COUNT_W-1:0]      body_count;
  logic [7:0]                        running_xor;
  logic [7:0]                        store [STORE_DEPTH];

  logic last_byte;

  // The end byte is checked live, so only bytes before it are stored
  assign last_byte = collecting && (body_count == hbfd_pkg::POS_END);

  always_ff @(posedge clk) begin
    if (rst) begin
      collecting  <= 1'b0;
      body_count  <= '0;
      running_xor <= '0;
    end else if (step) begin
      if (!collecting) begin
        if (rx_byte == hbfd_pkg::START_BYTE) begin
          collecting  <= 1'b1;
          body_count  <= '0;
          running_xor <= '0;
        end
      end else if (last_byte) begin
        collecting <= 1'b0;
        body_count <= '0;
      end else begin
        body_count <= body_count + 1'b1;
        if (body_count < hbfd_pkg::POS_CSUM) begin
          running_xor <= running_xor ^ rx_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && collecting && !last_byte) begin
      store[body_count] <= rx_byte;
    end
  end

  always_comb begin
    frame.ok    = step && last_byte && (rx_byte == hbfd_pkg::END_BYTE)
                  && (running_xor == store[hbfd_pkg::POS_CSUM]);
    frame.dest  = store[hbfd_pkg::POS_DEST];
    frame.cmd   = store[hbfd_pkg::POS_CMD];
    frame.data0 = store[hbfd_pkg::POS_DATA0];
    frame.data3 = store[hbfd_pkg::POS_DATA3];
    frame.data4 = store[hbfd_pkg::POS_DATA4];
    frame.data7 = store[hbfd_pkg::POS_DATA7];
  end

endmodule

>>> hdl/hbfd_tracker.sv
// Climate state tracker: applies status and mode frames, flags state changes.
// Depends on hbfd_pkg.
module hbfd_tracker (
  input  logic              clk,
  input  logic              rst,
  input  hbfd_pkg::frame_t  frame,
  input  logic [7:0]        unit_address,
  output hbfd_pkg::result_t result
);

  logic [5:0] held_temperature, held_temperature_next;
  logic       held_power, held_power_next;
  logic [1:0] held_fan, held_fan_next;
  logic [2:0] held_mode, held_mode_next;

  logic       for_us;
  logic [1:0] fan_decoded;

  assign for_us = frame.dest == unit_address;

  always_comb begin
    unique case (frame.data3[3:0])
      hbfd_pkg::FAN_NIB_LOW:  fan_decoded = hbfd_pkg::FAN_LOW;
      hbfd_pkg::FAN_NIB_MED:  fan_decoded = hbfd_pkg::FAN_MED;
      hbfd_pkg::FAN_NIB_HIGH: fan_decoded = hbfd_pkg::FAN_HIGH;
      default:                fan_decoded = hbfd_pkg::FAN_AUTO;
    endcase
  end

  always_comb begin
    held_temperature_next = held_temperature;
    held_power_next       = held_power;
    held_fan_next         = held_fan;
    held_mode_next        = held_mode;
    if (for_us && frame.cmd == hbfd_pkg::CMD_STATUS) begin
      held_temperature_next = {1'b0, frame.data0[4:0] & hbfd_pkg::TEMP_MASK}
                              + hbfd_pkg::TEMP_OFFSET;
      held_power_next       = frame.data4[7];
      held_fan_next         = fan_decoded;
    end
    if (for_us && frame.cmd == hbfd_pkg::CMD_MODE && frame.data7 <= hbfd_pkg::MODE_MAX) begin
      held_mode_next = frame.data7[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_temperature <= '0;
      held_power       <= 1'b0;
      held_fan         <= hbfd_pkg::FAN_AUTO;
      held_mode        <= '0;
    end else if (frame.ok) begin
      held_temperature <= held_temperature_next;
      held_power       <= held_power_next;
      held_fan         <= held_fan_next;
      held_mode        <= held_mode_next;
    end
  end

  always_comb begin
    result.temperature       = held_temperature_next;
    result.power_on          = held_power_next;
    result.fan_level         = held_fan_next;
    result.op_mode           = held_mode_next;
    result.frame_destination = frame.dest;
    // Two powered-off states count as equal
    if (!held_power && !held_power_next) begin
      result.state_changed = 1'b0;
    end else begin
      result.state_changed = (held_temperature != held_temperature_next)
                             || (held_power != held_power_next)
                             || (held_fan != held_fan_next)
                             || (held_mode != held_mode_next);
    end
  end

endmodule
